@@ design/c2s_pkg.sv @@
`default_nettype none
package c2s_pkg;

  localparam int COORD_BITS_DEF = 24;
  localparam int ANGLE_BITS_DEF = 24;

  // CORDIC datapath: coordinates are scaled so that they sit just under bit 59.
  localparam int CORDIC_W     = 64;
  localparam int CORDIC_ITERS = 32;
  localparam int SCALE_TOP    = 59;

  // Gain of the 32-step CORDIC in Q30.
  localparam logic [30:0] GAIN_Q30  = 31'd1768195363;
  localparam logic [31:0] HALF_TURN = 32'h8000_0000;

  // Stages in one CORDIC pass: one pre-rotation stage plus one stage per step.
  localparam int CORDIC_LAT = CORDIC_ITERS + 1;

  // Elementary angles atan(2^-i) as 32-bit fractions of a turn.
  function automatic logic [31:0] atan_turn(input int unsigned idx);
    logic [31:0] v;
    case (idx)
      0:  v = 32'h20000000;
      1:  v = 32'h12E4051E;
      2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;
      5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;
      7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2FA;
      15: v = 32'h0000517D;
      16: v = 32'h000028BE;
      17: v = 32'h0000145F;
      18: v = 32'h00000A30;
      19: v = 32'h00000518;
      20: v = 32'h0000028C;
      21: v = 32'h00000146;
      22: v = 32'h000000A3;
      23: v = 32'h00000051;
      24: v = 32'h00000029;
      25: v = 32'h00000014;
      26: v = 32'h0000000A;
      27: v = 32'h00000005;
      28: v = 32'h00000003;
      29: v = 32'h00000001;
      30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

@@ design/c2s_delay.sv @@
`default_nettype none
module c2s_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic [WIDTH-1:0] d_i,
  output logic      [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] tap_q [DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DEPTH; k++) tap_q[k] <= '0;
    end else if (en_i) begin
      tap_q[0] <= d_i;
      for (int k = 1; k < DEPTH; k++) tap_q[k] <= tap_q[k-1];
    end
  end

  assign q_o = tap_q[DEPTH-1];

endmodule
`default_nettype wire

@@ design/c2s_sqrt.sv @@
`default_nettype none
module c2s_sqrt #(
  parameter int CB = c2s_pkg::COORD_BITS_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            en_i,
  input  wire logic [2*CB-1:0] sq_x_i,
  input  wire logic [2*CB-1:0] sq_y_i,
  input  wire logic [2*CB-1:0] sq_z_i,
  output logic      [CB-1:0]   radius_o
);

  // One result bit per stage, restoring square root; the remainder is sq - root^2.
  logic [2*CB-1:0] n_q    [CB+1];
  logic [CB+1:0]   rem_q  [CB+1];
  logic [CB-1:0]   root_q [CB+1];
  logic [CB-1:0]   radius_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q[0]    <= sq_x_i + sq_y_i + sq_z_i;
      rem_q[0]  <= '0;
      root_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < CB; k++) begin : g_step
    logic [CB+1:0] rem_sh;
    logic [CB+1:0] trial;
    logic          take;

    assign rem_sh = {rem_q[k][CB-1:0], n_q[k][2*CB-1 -: 2]};
    assign trial  = {root_q[k], 2'b01};
    assign take   = (rem_sh >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[k+1]    <= {n_q[k][2*CB-3:0], 2'b00};
        rem_q[k+1]  <= take ? (rem_sh - trial) : rem_sh;
        root_q[k+1] <= {root_q[k][CB-2:0], take};
      end
    end
  end

  // Round to nearest: step up when the remainder exceeds the root.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      radius_q <= (rem_q[CB] > {2'b00, root_q[CB]}) ? root_q[CB] + 1'b1 : root_q[CB];
    end
  end

  assign radius_o = radius_q;

endmodule
`default_nettype wire

@@ design/c2s_cordic.sv @@
`default_nettype none
module c2s_cordic (
  input  wire logic                                clk_i,
  input  wire logic                                en_i,
  input  wire logic signed [c2s_pkg::CORDIC_W-1:0] x_i,
  input  wire logic signed [c2s_pkg::CORDIC_W-1:0] y_i,
  output logic signed      [c2s_pkg::CORDIC_W-1:0] mag_o,
  output logic             [31:0]                  angle_o
);

  localparam int N = c2s_pkg::CORDIC_ITERS;

  logic signed [c2s_pkg::CORDIC_W-1:0] x_q [N+1];
  logic signed [c2s_pkg::CORDIC_W-1:0] y_q [N+1];
  logic        [31:0]                  a_q [N+1];

  // Fold the left half-plane onto the right one.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (x_i < 0) begin
        x_q[0] <= -x_i;
        y_q[0] <= -y_i;
        a_q[0] <= c2s_pkg::HALF_TURN;
      end else begin
        x_q[0] <= x_i;
        y_q[0] <= y_i;
        a_q[0] <= '0;
      end
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_iter
    logic signed [c2s_pkg::CORDIC_W-1:0] xs;
    logic signed [c2s_pkg::CORDIC_W-1:0] ys;

    assign xs = x_q[k] >>> k;
    assign ys = y_q[k] >>> k;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (y_q[k] > 0) begin
          x_q[k+1] <= x_q[k] + ys;
          y_q[k+1] <= y_q[k] - xs;
          a_q[k+1] <= a_q[k] + c2s_pkg::atan_turn(k);
        end else begin
          x_q[k+1] <= x_q[k] - ys;
          y_q[k+1] <= y_q[k] + xs;
          a_q[k+1] <= a_q[k] - c2s_pkg::atan_turn(k);
        end
      end
    end
  end

  assign mag_o   = x_q[N];
  assign angle_o = a_q[N];

endmodule
`default_nettype wire

@@ design/cartesian_to_spherical.sv @@
// Cartesian to spherical converter. Each input word carries one signed point
// (x, y, z); each output word carries the rounded Euclidean radius, the
// azimuth atan2(y, x) in [0, full turn) and the polar angle acos(z/r) in
// [0, half turn], both angles as unsigned fractions of a turn scaled by
// 2^ANGLE_BITS. The azimuth is 0 for points on the z axis, and all three
// values are 0 at the origin. The block is a fully pipelined datapath: it
// accepts one word per clock when not stalled and keeps no state between
// words. Input to output runs through one multiply stage, two chained
// 33-stage CORDIC vectoring passes and one rounding and output stage;
// the square root runs alongside the first CORDIC pass and is delayed to
// line up. A stall on the output side freezes the whole pipeline, so the
// input is ready whenever the output register is empty or being drained.
`default_nettype none
module cartesian_to_spherical #(
  parameter int COORD_BITS = c2s_pkg::COORD_BITS_DEF,
  parameter int ANGLE_BITS = c2s_pkg::ANGLE_BITS_DEF,
  localparam int IN_W  = ((3 * COORD_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((COORD_BITS + 2 * ANGLE_BITS + 7) / 8) * 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  // Fields from bit 0 up: coord_x, coord_y, coord_z, zero fill.
  input  wire logic [IN_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  // Fields from bit 0 up: radius, azimuth, polar, zero fill.
  output logic      [OUT_W-1:0] m_axis_tdata
);

  localparam int CW        = c2s_pkg::CORDIC_W;
  localparam int SHIFT     = c2s_pkg::SCALE_TOP - COORD_BITS;
  localparam int PROD_W    = COORD_BITS + 31;
  localparam int WIDE_W    = PROD_W + SHIFT;
  localparam int ROUND_SH  = 32 - ANGLE_BITS;
  localparam logic [32:0] ROUND_ADD = (33'd1 << ROUND_SH) >> 1;
  localparam int PASS_LAT  = c2s_pkg::CORDIC_LAT;
  localparam int RAD_DELAY = 2 * PASS_LAT - (COORD_BITS + 2);

  // The whole pipeline advances together whenever the output slot can take a word.
  logic en;
  logic out_valid_q;

  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  logic signed [COORD_BITS-1:0] in_x, in_y, in_z;
  assign in_x = s_axis_tdata[0 +: COORD_BITS];
  assign in_y = s_axis_tdata[COORD_BITS +: COORD_BITS];
  assign in_z = s_axis_tdata[2*COORD_BITS +: COORD_BITS];

  // Stage B: squares, scaled x and y, and |z| times the CORDIC gain.
  logic signed [2*COORD_BITS-1:0] sqx_s, sqy_s, sqz_s;
  logic        [COORD_BITS-1:0]   abs_z;
  logic        [2*COORD_BITS-1:0] sqx_q, sqy_q, sqz_q;
  logic signed [CW-1:0]           xs_q, ys_q;
  logic        [PROD_W-1:0]       zprod_q;
  logic                           zneg_q, nz_xy_q, nz_all_q, vb_q;

  assign sqx_s = in_x * in_x;
  assign sqy_s = in_y * in_y;
  assign sqz_s = in_z * in_z;
  assign abs_z = in_z[COORD_BITS-1] ? COORD_BITS'(-in_z) : COORD_BITS'(in_z);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (en) begin
      vb_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqx_q    <= sqx_s;
      sqy_q    <= sqy_s;
      sqz_q    <= sqz_s;
      xs_q     <= CW'(in_x) <<< SHIFT;
      ys_q     <= CW'(in_y) <<< SHIFT;
      zprod_q  <= PROD_W'(abs_z) * PROD_W'(c2s_pkg::GAIN_Q30);
      zneg_q   <= in_z[COORD_BITS-1];
      nz_xy_q  <= (in_x != '0) || (in_y != '0);
      nz_all_q <= (in_x != '0) || (in_y != '0) || (in_z != '0);
    end
  end

  // z * 2^SHIFT * K truncated toward zero, signed.
  logic [WIDE_W-1:0]    zwide;
  logic signed [CW-1:0] zmag, zk;
  assign zwide = {zprod_q, {SHIFT{1'b0}}} >> 30;
  assign zmag  = CW'(zwide);
  assign zk    = zneg_q ? -zmag : zmag;

  // First pass: azimuth and the planar magnitude.
  logic signed [CW-1:0] mag1;
  logic        [31:0]   ang1;

  c2s_cordic u_pass_az (
    .clk_i  (clk_i),
    .en_i   (en),
    .x_i    (xs_q),
    .y_i    (ys_q),
    .mag_o  (mag1),
    .angle_o(ang1)
  );

  logic [CW+1:0] side1_d, side1_q;
  assign side1_d = {nz_all_q, nz_xy_q, zk};

  c2s_delay #(.WIDTH(CW + 2), .DEPTH(PASS_LAT)) u_side1 (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .d_i   (side1_d),
    .q_o   (side1_q)
  );

  // Second pass: polar angle from (z*K, planar magnitude).
  logic signed [CW-1:0] mag2;
  logic        [31:0]   ang2;

  c2s_cordic u_pass_pol (
    .clk_i  (clk_i),
    .en_i   (en),
    .x_i    (side1_q[CW-1:0]),
    .y_i    (mag1),
    .mag_o  (mag2),
    .angle_o(ang2)
  );

  logic [33:0] side2_d, side2_q;
  assign side2_d = {side1_q[CW+1], side1_q[CW], ang1};

  c2s_delay #(.WIDTH(34), .DEPTH(PASS_LAT)) u_side2 (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .d_i   (side2_d),
    .q_o   (side2_q)
  );

  // Radius runs beside the first pass and waits for the angles.
  logic [COORD_BITS-1:0] radius_raw, radius_al;

  c2s_sqrt #(.CB(COORD_BITS)) u_sqrt (
    .clk_i   (clk_i),
    .en_i    (en),
    .sq_x_i  (sqx_q),
    .sq_y_i  (sqy_q),
    .sq_z_i  (sqz_q),
    .radius_o(radius_raw)
  );

  c2s_delay #(.WIDTH(COORD_BITS), .DEPTH(RAD_DELAY)) u_rad_dly (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .d_i   (radius_raw),
    .q_o   (radius_al)
  );

  logic valid_al;

  c2s_delay #(.WIDTH(1), .DEPTH(2 * PASS_LAT)) u_vld_dly (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .d_i   (vb_q),
    .q_o   (valid_al)
  );

  // Round the 32-bit turn fractions to ANGLE_BITS; a full turn wraps to zero.
  logic [32:0]           az_sum, pol_sum;
  logic [ANGLE_BITS-1:0] az_d, pol_d;
  logic [ANGLE_BITS-1:0] az_q, pol_q;
  logic [COORD_BITS-1:0] radius_q;

  assign az_sum  = {1'b0, side2_q[31:0]} + ROUND_ADD;
  assign pol_sum = {1'b0, ang2} + ROUND_ADD;
  assign az_d    = side2_q[32] ? az_sum[ROUND_SH +: ANGLE_BITS] : '0;
  assign pol_d   = side2_q[33] ? pol_sum[ROUND_SH +: ANGLE_BITS] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= valid_al;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      radius_q <= radius_al;
      az_q     <= az_d;
      pol_q    <= pol_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'({pol_q, az_q, radius_q});

  // The second pass magnitude is not needed.
  logic unused_mag2;
  assign unused_mag2 = ^mag2;

endmodule
`default_nettype wire
